[src/conv_output_geometry_macros.svh]
// assertion macros for the convolution output geometry block
// used by the checker, no other dependencies
`ifndef CONV_OUTPUT_GEOMETRY_MACROS_SVH
`define CONV_OUTPUT_GEOMETRY_MACROS_SVH

// condition implies consequence in the same cycle
`define COG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define COG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cog_pkg.sv]
// shared widths, reciprocal table and stage types for the output geometry block
// no dependencies
`timescale 1ns / 1ps

package cog_pkg;

   // field widths
   localparam int IN_W     = 12;
   localparam int KERNEL_W = 8;
   localparam int STEP_W   = 4;
   localparam int PAD_W    = 8;
   localparam int DIM_W    = 13;
   localparam int END_W    = 14;

   // reciprocal scaling
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = DIM_W + RECIP_SHIFT;

   // axis indexes
   localparam int AXIS_Y = 0;
   localparam int AXIS_X = 1;
   localparam int AXES   = 2;

   // floor(2^16 / s), entry zero never used since stride zero reads as one
   localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21845,
      17'd16384, 17'd13107, 17'd10922, 17'd9362,
      17'd8192,  17'd7281,  17'd6553,  17'd5957,
      17'd5461,  17'd5041,  17'd4681,  17'd4369
   };

   // stage 1: numerators as magnitudes
   typedef struct packed {
      logic [DIM_W-1:0]  num_mag;
      logic [DIM_W-1:0]  a_num;
      logic [DIM_W-1:0]  b_mag;
      logic              b_neg;
      logic              num_neg;
      logic [STEP_W-1:0] stride;
   } st1_type;

   // stage 2: reciprocal products
   typedef struct packed {
      logic [DIM_W-1:0]  num_mag;
      logic [DIM_W-1:0]  a_num;
      logic [DIM_W-1:0]  b_mag;
      logic [PROD_W-1:0] num_prod;
      logic [PROD_W-1:0] a_prod;
      logic [PROD_W-1:0] b_prod;
      logic              b_neg;
      logic              num_neg;
      logic [STEP_W-1:0] stride;
   } st2_type;

   // stage 3: exact quotients
   typedef struct packed {
      logic [DIM_W-1:0] num_quot;
      logic [DIM_W-1:0] a_quot;
      logic [DIM_W-1:0] b_quot;
      logic             b_rem_nz;
      logic             b_neg;
      logic             num_neg;
   } st3_type;

   // quotient with remainder flag
   typedef struct packed {
      logic [DIM_W-1:0] quot;
      logic             rem_nz;
   } quot_type;

endpackage

[src/conv_output_geometry.sv]
// convolution output size and padding-free inner region, four stage pipeline
// depends on cog_pkg
`timescale 1ns / 1ps

// Takes one window geometry per transaction and returns output height and
// width, the padding-free inner region and a shape error flag. The pipeline
// has four register stages (numerators and dilated kernel, reciprocal
// multiply, quotient correction, output register); a new request can be
// accepted in every cycle while results are taken. The three divisions per
// axis by the stride are done as a multiply by a 17-bit reciprocal followed
// by one compare-and-subtract fix; that multiply stage sets the clock rate.
// A stalled result holds the pipeline only as far back as needed: empty
// stages keep filling.
module conv_output_geometry (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cog_pkg::IN_W-1:0]      req_in_height,
   input  logic [cog_pkg::IN_W-1:0]      req_in_width,
   input  logic [cog_pkg::KERNEL_W-1:0]  req_kernel_height,
   input  logic [cog_pkg::KERNEL_W-1:0]  req_kernel_width,
   input  logic [cog_pkg::STEP_W-1:0]    req_stride_y,
   input  logic [cog_pkg::STEP_W-1:0]    req_stride_x,
   input  logic [cog_pkg::STEP_W-1:0]    req_dilation_y,
   input  logic [cog_pkg::STEP_W-1:0]    req_dilation_x,
   input  logic [cog_pkg::PAD_W-1:0]     req_pad_top,
   input  logic [cog_pkg::PAD_W-1:0]     req_pad_left,
   input  logic [cog_pkg::PAD_W-1:0]     req_pad_bottom,
   input  logic [cog_pkg::PAD_W-1:0]     req_pad_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cog_pkg::DIM_W-1:0]     rsp_out_height,
   output logic [cog_pkg::DIM_W-1:0]     rsp_out_width,
   output logic [cog_pkg::DIM_W-1:0]     rsp_inner_top,
   output logic [cog_pkg::DIM_W-1:0]     rsp_inner_left,
   output logic signed [cog_pkg::END_W-1:0] rsp_inner_bottom,
   output logic signed [cog_pkg::END_W-1:0] rsp_inner_right,
   output logic                          rsp_shape_error
);

   localparam int DIM_W = cog_pkg::DIM_W;
   localparam int END_W = cog_pkg::END_W;
   localparam int AXES  = cog_pkg::AXES;

   // exact quotient from a reciprocal product, estimate is q or q-1
   function automatic cog_pkg::quot_type fix_quot(
      input logic [DIM_W-1:0]           n,
      input logic [cog_pkg::PROD_W-1:0] prod,
      input logic [cog_pkg::STEP_W-1:0] s
   );
      logic [DIM_W-1:0]   q0;
      logic [DIM_W+3:0]   qs;
      logic [DIM_W+3:0]   r0;
      cog_pkg::quot_type  res;
      q0 = prod[cog_pkg::PROD_W-1:cog_pkg::RECIP_SHIFT];
      qs = {4'd0, q0} * {{DIM_W{1'b0}}, s};
      r0 = {4'd0, n} - qs;
      if (r0 >= {{DIM_W{1'b0}}, s}) begin
         res.quot   = q0 + 1'b1;
         res.rem_nz = (r0 != {{DIM_W{1'b0}}, s});
      end else begin
         res.quot   = q0;
         res.rem_nz = (r0 != '0);
      end
      return res;
   endfunction

   // per-axis views of the request
   logic [cog_pkg::IN_W-1:0]     ax_in     [AXES];
   logic [cog_pkg::KERNEL_W-1:0] ax_kernel [AXES];
   logic [cog_pkg::STEP_W-1:0]   ax_stride [AXES];
   logic [cog_pkg::STEP_W-1:0]   ax_dil    [AXES];
   logic [cog_pkg::PAD_W-1:0]    ax_pad0   [AXES];
   logic [cog_pkg::PAD_W-1:0]    ax_pad1   [AXES];

   assign ax_in[cog_pkg::AXIS_Y]     = req_in_height;
   assign ax_in[cog_pkg::AXIS_X]     = req_in_width;
   assign ax_kernel[cog_pkg::AXIS_Y] = req_kernel_height;
   assign ax_kernel[cog_pkg::AXIS_X] = req_kernel_width;
   assign ax_stride[cog_pkg::AXIS_Y] = req_stride_y;
   assign ax_stride[cog_pkg::AXIS_X] = req_stride_x;
   assign ax_dil[cog_pkg::AXIS_Y]    = req_dilation_y;
   assign ax_dil[cog_pkg::AXIS_X]    = req_dilation_x;
   assign ax_pad0[cog_pkg::AXIS_Y]   = req_pad_top;
   assign ax_pad0[cog_pkg::AXIS_X]   = req_pad_left;
   assign ax_pad1[cog_pkg::AXIS_Y]   = req_pad_bottom;
   assign ax_pad1[cog_pkg::AXIS_X]   = req_pad_right;

   // pipeline registers
   logic              v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   cog_pkg::st1_type  st1_ff [AXES];
   cog_pkg::st1_type  st1_in [AXES];
   cog_pkg::st2_type  st2_ff [AXES];
   cog_pkg::st2_type  st2_in [AXES];
   cog_pkg::st3_type  st3_ff [AXES];
   cog_pkg::st3_type  st3_in [AXES];

   logic [DIM_W-1:0]        out_height_ff, out_width_ff, inner_top_ff, inner_left_ff;
   logic signed [END_W-1:0] inner_bottom_ff, inner_right_ff;
   logic                    shape_error_ff;
   logic [DIM_W-1:0]        out_height_in, out_width_in, inner_top_in, inner_left_in;
   logic signed [END_W-1:0] inner_bottom_in, inner_right_in;
   logic                    shape_error_in;

   // stage advance, each stage loads when the one after it can take its contents
   logic rdy2, rdy3, rdy4;
   assign rdy4      = !rsp_valid_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign req_ready = !v1_ff || rdy2;

   // stage 1: dilated kernel span and numerators
   always_comb begin
      logic signed [END_W-1:0] dk, num, bnum;
      logic [cog_pkg::STEP_W-1:0] s;
      for (int i = 0; i < AXES; i++) begin
         s  = (ax_stride[i] == '0) ? cog_pkg::STEP_W'(1) : ax_stride[i];
         dk = END_W'($signed({{(END_W-cog_pkg::STEP_W){1'b0}}, ax_dil[i]})
              * ($signed({{(END_W-cog_pkg::KERNEL_W){1'b0}}, ax_kernel[i]})
                 - END_W'(1)));
         num  = $signed({{(END_W-cog_pkg::IN_W){1'b0}}, ax_in[i]})
              + $signed({{(END_W-cog_pkg::PAD_W){1'b0}}, ax_pad0[i]})
              + $signed({{(END_W-cog_pkg::PAD_W){1'b0}}, ax_pad1[i]})
              - dk - END_W'(1);
         bnum = $signed({{(END_W-cog_pkg::IN_W){1'b0}}, ax_in[i]}) - dk
              + $signed({{(END_W-cog_pkg::PAD_W){1'b0}}, ax_pad0[i]});
         st1_in[i].num_neg = num[END_W-1];
         st1_in[i].num_mag = num[END_W-1] ? '0 : num[DIM_W-1:0];
         st1_in[i].b_neg   = bnum[END_W-1];
         st1_in[i].b_mag   = bnum[END_W-1] ? DIM_W'(-bnum) : bnum[DIM_W-1:0];
         st1_in[i].a_num   = {{(DIM_W-cog_pkg::PAD_W){1'b0}}, ax_pad0[i]}
                           + {{(DIM_W-cog_pkg::STEP_W){1'b0}}, s} - DIM_W'(1);
         st1_in[i].stride  = s;
      end
   end

   // stage 2: multiply by the stride reciprocal
   always_comb begin
      logic [cog_pkg::RECIP_W-1:0] r;
      for (int i = 0; i < AXES; i++) begin
         r = cog_pkg::RECIP_TABLE[st1_ff[i].stride];
         st2_in[i].num_mag  = st1_ff[i].num_mag;
         st2_in[i].a_num    = st1_ff[i].a_num;
         st2_in[i].b_mag    = st1_ff[i].b_mag;
         st2_in[i].num_prod = cog_pkg::PROD_W'(st1_ff[i].num_mag * r);
         st2_in[i].a_prod   = cog_pkg::PROD_W'(st1_ff[i].a_num * r);
         st2_in[i].b_prod   = cog_pkg::PROD_W'(st1_ff[i].b_mag * r);
         st2_in[i].b_neg    = st1_ff[i].b_neg;
         st2_in[i].num_neg  = st1_ff[i].num_neg;
         st2_in[i].stride   = st1_ff[i].stride;
      end
   end

   // stage 3: quotient correction
   always_comb begin
      cog_pkg::quot_type qn, qa, qb;
      for (int i = 0; i < AXES; i++) begin
         qn = fix_quot(st2_ff[i].num_mag, st2_ff[i].num_prod, st2_ff[i].stride);
         qa = fix_quot(st2_ff[i].a_num, st2_ff[i].a_prod, st2_ff[i].stride);
         qb = fix_quot(st2_ff[i].b_mag, st2_ff[i].b_prod, st2_ff[i].stride);
         st3_in[i].num_quot = qn.quot;
         st3_in[i].a_quot   = qa.quot;
         st3_in[i].b_quot   = qb.quot;
         st3_in[i].b_rem_nz = qb.rem_nz;
         st3_in[i].b_neg    = st2_ff[i].b_neg;
         st3_in[i].num_neg  = st2_ff[i].num_neg;
      end
   end

   // stage 4: sizes, region ends with ceiling, clip and empty check
   logic [DIM_W-1:0]        size_a  [AXES];
   logic signed [END_W-1:0] end_a   [AXES];
   logic                    empty_a [AXES];

   always_comb begin
      logic signed [END_W-1:0] b, ho_s;
      for (int i = 0; i < AXES; i++) begin
         size_a[i] = st3_ff[i].num_neg ? '0 : st3_ff[i].num_quot + 1'b1;
         ho_s      = $signed({1'b0, size_a[i]});
         // truncation of a negative value is already its ceiling
         if (st3_ff[i].b_neg) begin
            b = -$signed({1'b0, st3_ff[i].b_quot});
         end else begin
            b = $signed({1'b0, st3_ff[i].b_quot})
              + $signed({{(END_W-1){1'b0}}, st3_ff[i].b_rem_nz});
         end
         end_a[i]   = (b > ho_s) ? ho_s : b;
         empty_a[i] = ($signed({1'b0, st3_ff[i].a_quot}) >= end_a[i]);
      end
      out_height_in   = size_a[cog_pkg::AXIS_Y];
      out_width_in    = size_a[cog_pkg::AXIS_X];
      inner_bottom_in = end_a[cog_pkg::AXIS_Y];
      inner_right_in  = end_a[cog_pkg::AXIS_X];
      shape_error_in  = st3_ff[cog_pkg::AXIS_Y].num_neg || st3_ff[cog_pkg::AXIS_X].num_neg;
      if (empty_a[cog_pkg::AXIS_Y] || empty_a[cog_pkg::AXIS_X]) begin
         inner_top_in  = size_a[cog_pkg::AXIS_Y];
         inner_left_in = size_a[cog_pkg::AXIS_X];
      end else begin
         inner_top_in  = st3_ff[cog_pkg::AXIS_Y].a_quot;
         inner_left_in = st3_ff[cog_pkg::AXIS_X].a_quot;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) v1_ff <= req_valid;
         if (rdy2)      v2_ff <= v1_ff;
         if (rdy3)      v3_ff <= v2_ff;
         if (rdy4)      rsp_valid_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready) st1_ff <= st1_in;
      if (rdy2)      st2_ff <= st2_in;
      if (rdy3)      st3_ff <= st3_in;
      if (rdy4) begin
         out_height_ff   <= out_height_in;
         out_width_ff    <= out_width_in;
         inner_top_ff    <= inner_top_in;
         inner_left_ff   <= inner_left_in;
         inner_bottom_ff <= inner_bottom_in;
         inner_right_ff  <= inner_right_in;
         shape_error_ff  <= shape_error_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_height   = out_height_ff;
   assign rsp_out_width    = out_width_ff;
   assign rsp_inner_top    = inner_top_ff;
   assign rsp_inner_left   = inner_left_ff;
   assign rsp_inner_bottom = inner_bottom_ff;
   assign rsp_inner_right  = inner_right_ff;
   assign rsp_shape_error  = shape_error_ff;

endmodule

[src/cog_checker.sv]
// port-level checks for the output geometry block, bound to the top level
// depends on cog_pkg and conv_output_geometry_macros.svh
`timescale 1ns / 1ps
`include "conv_output_geometry_macros.svh"

module cog_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cog_pkg::DIM_W-1:0]         rsp_out_height,
   input logic [cog_pkg::DIM_W-1:0]         rsp_out_width,
   input logic [cog_pkg::DIM_W-1:0]         rsp_inner_top,
   input logic [cog_pkg::DIM_W-1:0]         rsp_inner_left,
   input logic signed [cog_pkg::END_W-1:0]  rsp_inner_bottom,
   input logic signed [cog_pkg::END_W-1:0]  rsp_inner_right,
   input logic                              rsp_shape_error
);

   // a stalled transaction stays valid and holds its height and bottom end
   `COG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_height) && $stable(rsp_inner_bottom), "stalled result changed")

   // error flag exactly when an axis collapses to zero size
   `COG_ASSERT_NOW(a_err_size, rsp_valid, rsp_shape_error == ((rsp_out_height == '0) || (rsp_out_width == '0)), "shape error disagrees with sizes")

   // region ends never pass the output size
   `COG_ASSERT_NOW(a_end_clip, rsp_valid, (rsp_inner_bottom <= $signed({1'b0, rsp_out_height})) && (rsp_inner_right <= $signed({1'b0, rsp_out_width})), "inner end beyond output size")

   // region start is either the collapsed size or before the end
   `COG_ASSERT_NOW(a_start_ok, rsp_valid, ((rsp_inner_top == rsp_out_height) && (rsp_inner_left == rsp_out_width)) || (($signed({1'b0, rsp_inner_top}) < rsp_inner_bottom) && ($signed({1'b0, rsp_inner_left}) < rsp_inner_right)), "inner start inconsistent")

endmodule

bind conv_output_geometry cog_checker u_cog_checker (.*);

[tb/tb_conv_output_geometry.sv]
// self-checking testbench for the convolution output geometry block
// drives random and corner-case window geometries, predicts every result, checks in order
// depends on cog_pkg and conv_output_geometry
`timescale 1ns / 1ps

module tb_conv_output_geometry;

   localparam int IN_W     = cog_pkg::IN_W;
   localparam int KERNEL_W = cog_pkg::KERNEL_W;
   localparam int STEP_W   = cog_pkg::STEP_W;
   localparam int PAD_W    = cog_pkg::PAD_W;
   localparam int DIM_W    = cog_pkg::DIM_W;
   localparam int END_W    = cog_pkg::END_W;

   // one window geometry request and one geometry result
   typedef struct {
      logic [IN_W-1:0]     in_height;
      logic [IN_W-1:0]     in_width;
      logic [KERNEL_W-1:0] kernel_height;
      logic [KERNEL_W-1:0] kernel_width;
      logic [STEP_W-1:0]   stride_y;
      logic [STEP_W-1:0]   stride_x;
      logic [STEP_W-1:0]   dilation_y;
      logic [STEP_W-1:0]   dilation_x;
      logic [PAD_W-1:0]    pad_top;
      logic [PAD_W-1:0]    pad_left;
      logic [PAD_W-1:0]    pad_bottom;
      logic [PAD_W-1:0]    pad_right;
   } geom_req_type;

   typedef struct {
      logic [DIM_W-1:0]        out_height;
      logic [DIM_W-1:0]        out_width;
      logic [DIM_W-1:0]        inner_top;
      logic [DIM_W-1:0]        inner_left;
      logic signed [END_W-1:0] inner_bottom;
      logic signed [END_W-1:0] inner_right;
      logic                    shape_error;
   } geom_rsp_type;

   localparam int RANDOM_ITEMS  = 550;
   localparam int HOLD_CYCLES   = 200;
   localparam int QUIET_FIRST   = 250;
   localparam int QUIET_LAST    = 370;
   localparam int DRAIN_CYCLES  = 20;

   logic clock;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [IN_W-1:0]         req_in_height = '0;
   logic [IN_W-1:0]         req_in_width = '0;
   logic [KERNEL_W-1:0]     req_kernel_height = '0;
   logic [KERNEL_W-1:0]     req_kernel_width = '0;
   logic [STEP_W-1:0]       req_stride_y = '0;
   logic [STEP_W-1:0]       req_stride_x = '0;
   logic [STEP_W-1:0]       req_dilation_y = '0;
   logic [STEP_W-1:0]       req_dilation_x = '0;
   logic [PAD_W-1:0]        req_pad_top = '0;
   logic [PAD_W-1:0]        req_pad_left = '0;
   logic [PAD_W-1:0]        req_pad_bottom = '0;
   logic [PAD_W-1:0]        req_pad_right = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DIM_W-1:0]        rsp_out_height;
   logic [DIM_W-1:0]        rsp_out_width;
   logic [DIM_W-1:0]        rsp_inner_top;
   logic [DIM_W-1:0]        rsp_inner_left;
   logic signed [END_W-1:0] rsp_inner_bottom;
   logic signed [END_W-1:0] rsp_inner_right;
   logic                    rsp_shape_error;

   geom_req_type pending_geoms[$];
   geom_rsp_type expected_geoms[$];
   geom_req_type offered_geom;
   int           geoms_accepted = 0;
   int           geoms_checked = 0;
   int           error_count = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;

   conv_output_geometry uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_height     (req_in_height),
      .req_in_width      (req_in_width),
      .req_kernel_height (req_kernel_height),
      .req_kernel_width  (req_kernel_width),
      .req_stride_y      (req_stride_y),
      .req_stride_x      (req_stride_x),
      .req_dilation_y    (req_dilation_y),
      .req_dilation_x    (req_dilation_x),
      .req_pad_top       (req_pad_top),
      .req_pad_left      (req_pad_left),
      .req_pad_bottom    (req_pad_bottom),
      .req_pad_right     (req_pad_right),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_height    (rsp_out_height),
      .rsp_out_width     (rsp_out_width),
      .rsp_inner_top     (rsp_inner_top),
      .rsp_inner_left    (rsp_inner_left),
      .rsp_inner_bottom  (rsp_inner_bottom),
      .rsp_inner_right   (rsp_inner_right),
      .rsp_shape_error   (rsp_shape_error)
   );

   // one axis: output size, padding-free range and kernel overflow flag
   function automatic void axis_geometry(input longint span, input longint kernel,
                                         input longint stride, input longint dilation,
                                         input longint pad_lo, input longint pad_hi,
                                         output longint size, output longint first,
                                         output longint stop_pos, output bit overflow);
      longint num;
      longint quot;
      num = span + pad_lo + pad_hi - dilation * (kernel - 1) - 1;
      overflow = (num < 0);
      size = overflow ? 0 : num / stride + 1;
      first = (pad_lo + stride - 1) / stride;
      quot = (span - (kernel - 1) * dilation + pad_lo) / stride;
      if (quot * stride - pad_lo + (kernel - 1) * dilation < span)
         quot = quot + 1;
      if (quot > size)
         quot = size;
      stop_pos = quot;
   endfunction

   // full geometry result for one request
   function automatic geom_rsp_type predict_geometry(geom_req_type g);
      geom_rsp_type r;
      longint       sy, sx, ho, wo, y0, y1, x0, x1;
      bit           err_y, err_x;
      // a zero stride reads as one
      sy = (g.stride_y == '0) ? longint'(1) : longint'(g.stride_y);
      sx = (g.stride_x == '0) ? longint'(1) : longint'(g.stride_x);
      axis_geometry(longint'(g.in_height), longint'(g.kernel_height), sy,
                    longint'(g.dilation_y), longint'(g.pad_top), longint'(g.pad_bottom),
                    ho, y0, y1, err_y);
      axis_geometry(longint'(g.in_width), longint'(g.kernel_width), sx,
                    longint'(g.dilation_x), longint'(g.pad_left), longint'(g.pad_right),
                    wo, x0, x1, err_x);
      // empty region on either axis moves the start to the output size
      if (y0 >= y1 || x0 >= x1) begin
         y0 = ho;
         x0 = wo;
      end
      r.out_height   = ho[DIM_W-1:0];
      r.out_width    = wo[DIM_W-1:0];
      r.inner_top    = y0[DIM_W-1:0];
      r.inner_left   = x0[DIM_W-1:0];
      r.inner_bottom = y1[END_W-1:0];
      r.inner_right  = x1[END_W-1:0];
      r.shape_error  = err_y | err_x;
      return r;
   endfunction

   function automatic void add_geometry(int h, int w, int kh, int kw, int sy, int sx,
                                        int dy, int dx, int pt, int pl, int pb, int pr);
      geom_req_type g;
      g.in_height     = IN_W'(h);
      g.in_width      = IN_W'(w);
      g.kernel_height = KERNEL_W'(kh);
      g.kernel_width  = KERNEL_W'(kw);
      g.stride_y      = STEP_W'(sy);
      g.stride_x      = STEP_W'(sx);
      g.dilation_y    = STEP_W'(dy);
      g.dilation_x    = STEP_W'(dx);
      g.pad_top       = PAD_W'(pt);
      g.pad_left      = PAD_W'(pl);
      g.pad_bottom    = PAD_W'(pb);
      g.pad_right     = PAD_W'(pr);
      pending_geoms.push_back(g);
   endfunction

   // mostly layer-like shapes, some full-range noise, some near the overflow edge
   function automatic geom_req_type random_geometry();
      geom_req_type g;
      int           mode;
      mode = $urandom_range(9);
      if (mode <= 5) begin
         g.in_height     = IN_W'($urandom_range(1, 64));
         g.in_width      = IN_W'($urandom_range(1, 64));
         g.kernel_height = KERNEL_W'($urandom_range(1, 7));
         g.kernel_width  = KERNEL_W'($urandom_range(1, 7));
         g.stride_y      = STEP_W'($urandom_range(1, 4));
         g.stride_x      = STEP_W'($urandom_range(1, 4));
         g.dilation_y    = STEP_W'($urandom_range(1, 3));
         g.dilation_x    = STEP_W'($urandom_range(1, 3));
         g.pad_top       = PAD_W'($urandom_range(0, 32'(g.kernel_height)));
         g.pad_left      = PAD_W'($urandom_range(0, 32'(g.kernel_width)));
         g.pad_bottom    = PAD_W'($urandom_range(0, 32'(g.kernel_height)));
         g.pad_right     = PAD_W'($urandom_range(0, 32'(g.kernel_width)));
         // one-dimensional case now and then
         if ($urandom_range(3) == 0) begin
            g.in_height     = IN_W'(1);
            g.kernel_height = KERNEL_W'(1);
            g.pad_top       = '0;
            g.pad_bottom    = '0;
         end
      end else if (mode <= 8) begin
         g.in_height     = IN_W'($urandom());
         g.in_width      = IN_W'($urandom());
         g.kernel_height = KERNEL_W'($urandom());
         g.kernel_width  = KERNEL_W'($urandom());
         g.stride_y      = STEP_W'($urandom());
         g.stride_x      = STEP_W'($urandom());
         g.dilation_y    = STEP_W'($urandom());
         g.dilation_x    = STEP_W'($urandom());
         g.pad_top       = PAD_W'($urandom());
         g.pad_left      = PAD_W'($urandom());
         g.pad_bottom    = PAD_W'($urandom());
         g.pad_right     = PAD_W'($urandom());
      end else begin
         g.in_height     = IN_W'($urandom_range(0, 40));
         g.in_width      = IN_W'($urandom_range(0, 40));
         g.kernel_height = KERNEL_W'($urandom_range(0, 40));
         g.kernel_width  = KERNEL_W'($urandom_range(0, 40));
         g.stride_y      = STEP_W'($urandom());
         g.stride_x      = STEP_W'($urandom());
         g.dilation_y    = STEP_W'($urandom_range(0, 3));
         g.dilation_x    = STEP_W'($urandom_range(0, 3));
         g.pad_top       = PAD_W'($urandom_range(0, 8));
         g.pad_left      = PAD_W'($urandom_range(0, 8));
         g.pad_bottom    = PAD_W'($urandom_range(0, 8));
         g.pad_right     = PAD_W'($urandom_range(0, 8));
      end
      return g;
   endfunction

   function automatic void check_field(string name, logic signed [15:0] expected_val,
                                       logic signed [15:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
         error_count++;
      end
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // request driver: offers the next pending geometry once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_geoms.push_back(predict_geometry(offered_geom));
            geoms_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_geoms.size() != 0 &&
                !((geoms_accepted < QUIET_FIRST || geoms_accepted >= QUIET_LAST) &&
                  $urandom_range(99) < 7)) begin
               offered_geom = pending_geoms.pop_front();
               req_in_height     <= offered_geom.in_height;
               req_in_width      <= offered_geom.in_width;
               req_kernel_height <= offered_geom.kernel_height;
               req_kernel_width  <= offered_geom.kernel_width;
               req_stride_y      <= offered_geom.stride_y;
               req_stride_x      <= offered_geom.stride_x;
               req_dilation_y    <= offered_geom.dilation_y;
               req_dilation_x    <= offered_geom.dilation_x;
               req_pad_top       <= offered_geom.pad_top;
               req_pad_left      <= offered_geom.pad_left;
               req_pad_bottom    <= offered_geom.pad_bottom;
               req_pad_right     <= offered_geom.pad_right;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result ready: random stalls, a quiet stretch and one long hold-off to back up the pipe
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && geoms_accepted >= 120) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (geoms_checked >= QUIET_FIRST && geoms_checked < QUIET_LAST) ||
                      ($urandom_range(99) >= 7);
      end
   end

   // result monitor: each result against the oldest prediction
   always @(posedge clock) begin
      geom_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_geoms.size() == 0) begin
            $error("result transaction with no request outstanding");
            error_count++;
         end else begin
            want = expected_geoms.pop_front();
            check_field("out_height", 16'(want.out_height), 16'(rsp_out_height));
            check_field("out_width", 16'(want.out_width), 16'(rsp_out_width));
            check_field("inner_top", 16'(want.inner_top), 16'(rsp_inner_top));
            check_field("inner_left", 16'(want.inner_left), 16'(rsp_inner_left));
            check_field("inner_bottom", 16'(want.inner_bottom), 16'(rsp_inner_bottom));
            check_field("inner_right", 16'(want.inner_right), 16'(rsp_inner_right));
            check_field("shape_error", 16'(want.shape_error), 16'(rsp_shape_error));
         end
         geoms_checked++;
      end
   end

   // stimulus and end of run
   initial begin
      // smallest and largest fields
      add_geometry(1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
      add_geometry(4095, 4095, 255, 255, 15, 15, 15, 15, 255, 255, 255, 255);
      add_geometry(4095, 4095, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
      add_geometry(12'hAAA, 12'h555, 8'hAA, 8'h55, 4'hA, 4'h5, 4'h5, 4'hA,
                   8'h55, 8'hAA, 8'hAA, 8'h55);
      // kernel larger than padded input, height only then width only
      add_geometry(3, 16, 5, 3, 1, 1, 1, 1, 0, 1, 0, 1);
      add_geometry(16, 3, 3, 5, 1, 1, 1, 1, 1, 0, 1, 0);
      // kernel fits exactly
      add_geometry(5, 5, 5, 5, 1, 1, 1, 1, 0, 0, 0, 0);
      // huge dilated kernel on a tiny input, region end goes negative
      add_geometry(1, 1, 255, 255, 3, 7, 15, 15, 255, 255, 255, 255);
      // zero stride reads as one
      add_geometry(10, 12, 3, 3, 0, 0, 1, 1, 1, 1, 1, 1);
      // zero dilation, zero kernel, zero input size
      add_geometry(10, 12, 3, 5, 2, 1, 0, 0, 1, 2, 1, 2);
      add_geometry(10, 12, 0, 0, 1, 2, 1, 1, 0, 0, 0, 0);
      add_geometry(0, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
      add_geometry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // one-dimensional window
      add_geometry(1, 200, 1, 9, 1, 2, 1, 2, 0, 4, 0, 4);
      // padding larger than the stride rounds the start up
      add_geometry(32, 32, 7, 7, 4, 3, 1, 1, 6, 5, 6, 5);
      // heavy padding, the first of these leaves an empty inner region
      add_geometry(2, 2, 3, 3, 4, 4, 1, 1, 5, 5, 5, 5);
      add_geometry(1, 1, 1, 1, 15, 15, 15, 15, 255, 255, 255, 255);
      // max stride and dilation with a small kernel
      add_geometry(100, 77, 2, 3, 15, 15, 15, 15, 0, 3, 7, 0);
      repeat (RANDOM_ITEMS) pending_geoms.push_back(random_geometry());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, accepted and answered, then a short quiet tail
      while (pending_geoms.size() != 0 || req_valid || expected_geoms.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_geoms.size() != 0) begin
         $error("%0d results never arrived", expected_geoms.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("conv_output_geometry: match");
      end else begin
         $display("conv_output_geometry: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("conv_output_geometry: mismatch");
      $finish;
   end

endmodule

[conv_output_geometry.f]
+incdir+src
src/cog_pkg.sv
src/conv_output_geometry.sv
src/cog_checker.sv
tb/tb_conv_output_geometry.sv
